// ===== hdl/assert_macros.svh =====
// Assertion helpers, sampled on clk, off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RSYNC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsync check failed");

// next-cycle implication
`define RSYNC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsync check failed");

`endif

// ===== hdl/rsync_pkg.sv =====
package rsync_pkg;

    typedef enum logic [2:0]
    {
        SYNC_BOOT   = 3'd0,
        SYNC_QUASI  = 3'd1,
        SYNC_SYNCED = 3'd2,
        SYNC_UNS1   = 3'd3,
        SYNC_UNS2   = 3'd4,
        SYNC_UNS3   = 3'd5
    } sync_state_t;

    typedef enum logic [3:0]
    {
        SEQ_IDLE,
        SEQ_DECIDE,
        SEQ_MUL_DT,
        SEQ_DIV_INIT,
        SEQ_DIV,
        SEQ_DIV_FIX,
        SEQ_POST,
        SEQ_ADV_T,
        SEQ_ADV_S,
        SEQ_OUT
    } seq_state_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TPS          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_SYNCED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_MISS1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_MISS2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_WIDE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PKT_CODE     = 3'd6;

    localparam logic [15:0] RST_TPS          = 16'd32768;
    localparam logic [15:0] RST_GUARD_SYNCED = 16'd16;
    localparam logic [15:0] RST_GUARD_MISS1  = 16'd32;
    localparam logic [15:0] RST_GUARD_MISS2  = 16'd64;
    localparam logic [15:0] RST_GUARD_WIDE   = 16'd128;
    localparam logic [7:0]  RST_MIN_LEN      = 8'd8;
    localparam logic [7:0]  RST_PKT_CODE     = 8'd0;

    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

endpackage

// ===== hdl/rsync_in_if.sv =====
interface rsync_in_if;
    logic        valid;
    logic        ready;
    logic        flood_synced;
    logic [7:0]  payload_len;
    logic [7:0]  pkt_code;
    logic [31:0] rx_ref_tick;
    logic [31:0] rx_sched_time;
    logic [15:0] rx_round_period;

    modport source
    (
        output valid, flood_synced, payload_len, pkt_code,
               rx_ref_tick, rx_sched_time, rx_round_period,
        input  ready
    );

    modport sink
    (
        input  valid, flood_synced, payload_len, pkt_code,
               rx_ref_tick, rx_sched_time, rx_round_period,
        output ready
    );
endinterface

// ===== hdl/rsync_out_if.sv =====
interface rsync_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         sync_state_out;
    logic [15:0]        guard_out;
    logic [31:0]        ref_tick_out;
    logic signed [31:0] skew_out;
    logic [31:0]        wake_tick;
    logic               decode_schedule;
    logic               run_data_round;

    modport source
    (
        output valid, sync_state_out, guard_out, ref_tick_out, skew_out,
               wake_tick, decode_schedule, run_data_round,
        input  ready
    );

    modport sink
    (
        input  valid, sync_state_out, guard_out, ref_tick_out, skew_out,
               wake_tick, decode_schedule, run_data_round,
        output ready
    );
endinterface

// ===== hdl/round_sync_tracker.sv =====
// Round synchronization tracker.
// sched_rx: one transfer per radio round with the outcome of the schedule
//   reception. ready is high only while the sequencer is idle.
// result: one transfer per accepted item: sync state, guard, reference tick,
//   skew, next wake tick and the round-run flags, held in an output register.
// cfg_we/cfg_index/cfg_data: register writes, taken on any edge with cfg_we.
// Path per item: a miss that ends in bootstrap goes straight to output; a
// predicted miss, a first (quasi) sync and a full sync post and advance the
// ticks, and a full sync first divides out a new skew unless its schedule
// time is unchanged. The sequencer then returns to idle before it accepts
// another item. The work is done by the 32-step restoring divider and by
// the single 16x32 multiplier that all tick products share.
// Reset: state bootstrap, all tracked values zero, registers at defaults.
// If the result is not taken, it holds in the output register; the next
// item is still accepted and worked, then waits in the sequencer until the
// register frees, and no further item is accepted meanwhile.
module round_sync_tracker
    import rsync_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    rsync_in_if.sink              sched_rx,
    rsync_out_if.source           result
);

    logic [15:0] tps_reg, g_sync_reg, g_miss1_reg, g_miss2_reg, g_wide_reg;
    logic [7:0]  min_len_reg, pkt_code_reg;

    seq_state_t  seq_reg, seq_next;
    sync_state_t sync_reg, sync_next;
    logic [15:0] guard_reg, guard_next;
    logic [31:0] ref_reg, ref_next;
    logic [31:0] last_ref_reg, last_ref_next;
    logic [31:0] skew_reg, skew_next;
    logic [31:0] last_time_reg, last_time_next;
    logic [15:0] last_period_reg, last_period_next;

    logic        pred_reg, pred_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] dt_reg, dt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;

    logic        flood_reg;
    logic [7:0]  len_reg, code_reg;
    logic [31:0] rx_ref_reg, rx_time_reg;
    logic [15:0] rx_period_reg;

    logic [2:0]  o_state_reg;
    logic [15:0] o_guard_reg;
    logic [31:0] o_ref_reg, o_skew_reg, o_wake_reg;
    logic        o_decode_reg, o_run_reg;

    logic        in_xfer, out_load, rx_valid, div_ge;
    logic [15:0] mul_a;
    logic [31:0] mul_b, prod;
    logic [47:0] prod_full;
    logic [32:0] rem_sh, div_diff;

    assign sched_rx.ready = (seq_reg == SEQ_IDLE);
    assign in_xfer        = sched_rx.valid && sched_rx.ready;

    // shared multiplier, low word only
    assign mul_a     = (seq_reg == SEQ_MUL_DT) ? tps_reg : last_period_reg;
    assign mul_b     = (seq_reg == SEQ_MUL_DT) ? dt_reg
                     : (seq_reg == SEQ_ADV_T)  ? {16'd0, tps_reg} : skew_reg;
    assign prod_full = mul_a * mul_b;
    assign prod      = prod_full[31:0];

    assign rx_valid = flood_reg && (len_reg >= min_len_reg) && (code_reg == pkt_code_reg);

    assign rem_sh   = {rem_reg, quo_reg[DIV_W-1]};
    assign div_diff = rem_sh - {1'b0, den_reg};
    assign div_ge   = !div_diff[32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg      <= RST_TPS;
            g_sync_reg   <= RST_GUARD_SYNCED;
            g_miss1_reg  <= RST_GUARD_MISS1;
            g_miss2_reg  <= RST_GUARD_MISS2;
            g_wide_reg   <= RST_GUARD_WIDE;
            min_len_reg  <= RST_MIN_LEN;
            pkt_code_reg <= RST_PKT_CODE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TPS:          tps_reg      <= cfg_data;
                CFG_GUARD_SYNCED: g_sync_reg   <= cfg_data;
                CFG_GUARD_MISS1:  g_miss1_reg  <= cfg_data;
                CFG_GUARD_MISS2:  g_miss2_reg  <= cfg_data;
                CFG_GUARD_WIDE:   g_wide_reg   <= cfg_data;
                CFG_MIN_LEN:      min_len_reg  <= cfg_data[7:0];
                CFG_PKT_CODE:     pkt_code_reg <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        seq_next         = seq_reg;
        sync_next        = sync_reg;
        guard_next       = guard_reg;
        ref_next         = ref_reg;
        last_ref_next    = last_ref_reg;
        skew_next        = skew_reg;
        last_time_next   = last_time_reg;
        last_period_next = last_period_reg;
        pred_next        = pred_reg;
        acc_next         = acc_reg;
        dt_next          = dt_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        den_next         = den_reg;
        neg_next         = neg_reg;
        cnt_next         = cnt_reg;
        out_load         = 1'b0;
        out_valid_next   = out_valid_reg && !result.ready;

        unique case (seq_reg)
            SEQ_IDLE:
            begin
                if (sched_rx.valid)
                begin
                    seq_next = SEQ_DECIDE;
                end
            end
            SEQ_DECIDE:
            begin
                if (rx_valid)
                begin
                    ref_next  = rx_ref_reg;
                    pred_next = 1'b0;
                    if (sync_reg == SYNC_BOOT)
                    begin
                        sync_next  = SYNC_QUASI;
                        guard_next = g_wide_reg;
                        seq_next   = SEQ_POST;
                    end
                    else
                    begin
                        sync_next  = SYNC_SYNCED;
                        guard_next = g_sync_reg;
                        dt_next    = rx_time_reg - last_time_reg;
                        acc_next   = rx_ref_reg - last_ref_reg;
                        seq_next   = (rx_time_reg == last_time_reg) ? SEQ_POST : SEQ_MUL_DT;
                    end
                end
                else
                begin
                    pred_next = 1'b1;
                    acc_next  = last_ref_reg;
                    seq_next  = SEQ_ADV_T;
                    unique case (sync_reg)
                        SYNC_SYNCED:
                        begin
                            sync_next  = SYNC_UNS1;
                            guard_next = g_miss1_reg;
                        end
                        SYNC_UNS1:
                        begin
                            sync_next  = SYNC_UNS2;
                            guard_next = g_miss2_reg;
                        end
                        SYNC_UNS2:
                        begin
                            sync_next  = SYNC_UNS3;
                            guard_next = g_wide_reg;
                        end
                        SYNC_UNS3, SYNC_QUASI:
                        begin
                            sync_next  = SYNC_BOOT;
                            guard_next = g_wide_reg;
                            skew_next  = '0;
                            seq_next   = SEQ_OUT;
                        end
                        default:
                        begin
                            seq_next = SEQ_OUT;
                        end
                    endcase
                end
            end
            SEQ_MUL_DT:
            begin
                acc_next = acc_reg - prod;
                seq_next = SEQ_DIV_INIT;
            end
            SEQ_DIV_INIT:
            begin
                neg_next = acc_reg[31] ^ dt_reg[31];
                quo_next = acc_reg[31] ? (32'd0 - acc_reg) : acc_reg;
                den_next = dt_reg[31] ? (32'd0 - dt_reg) : dt_reg;
                rem_next = '0;
                cnt_next = '0;
                seq_next = SEQ_DIV;
            end
            SEQ_DIV:
            begin
                rem_next = div_ge ? div_diff[31:0] : rem_sh[31:0];
                quo_next = {quo_reg[DIV_W-2:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    seq_next = SEQ_DIV_FIX;
                end
            end
            SEQ_DIV_FIX:
            begin
                skew_next = neg_reg ? (32'd0 - quo_reg) : quo_reg;
                seq_next  = SEQ_POST;
            end
            SEQ_POST:
            begin
                if (sync_reg == SYNC_QUASI || sync_reg == SYNC_SYNCED)
                begin
                    last_time_next   = rx_time_reg;
                    last_period_next = rx_period_reg;
                end
                else
                begin
                    last_time_next = last_time_reg + {16'd0, last_period_reg};
                end
                last_ref_next = ref_reg;
                acc_next      = ref_reg - {16'd0, guard_reg};
                pred_next     = 1'b0;
                seq_next      = SEQ_ADV_T;
            end
            SEQ_ADV_T:
            begin
                acc_next = acc_reg + prod;
                seq_next = SEQ_ADV_S;
            end
            SEQ_ADV_S:
            begin
                acc_next = acc_reg + prod;
                if (pred_reg)
                begin
                    ref_next = acc_reg + prod;
                    seq_next = SEQ_POST;
                end
                else
                begin
                    seq_next = SEQ_OUT;
                end
            end
            SEQ_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    seq_next       = SEQ_IDLE;
                end
            end
            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg         <= SEQ_IDLE;
            sync_reg        <= SYNC_BOOT;
            guard_reg       <= '0;
            ref_reg         <= '0;
            last_ref_reg    <= '0;
            skew_reg        <= '0;
            last_time_reg   <= '0;
            last_period_reg <= '0;
            pred_reg        <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            seq_reg         <= seq_next;
            sync_reg        <= sync_next;
            guard_reg       <= guard_next;
            ref_reg         <= ref_next;
            last_ref_reg    <= last_ref_next;
            skew_reg        <= skew_next;
            last_time_reg   <= last_time_next;
            last_period_reg <= last_period_next;
            pred_reg        <= pred_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // datapath scratch, no reset
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        dt_reg  <= dt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            flood_reg     <= sched_rx.flood_synced;
            len_reg       <= sched_rx.payload_len;
            code_reg      <= sched_rx.pkt_code;
            rx_ref_reg    <= sched_rx.rx_ref_tick;
            rx_time_reg   <= sched_rx.rx_sched_time;
            rx_period_reg <= sched_rx.rx_round_period;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_state_reg  <= sync_reg;
            o_guard_reg  <= guard_reg;
            o_ref_reg    <= ref_reg;
            o_skew_reg   <= skew_reg;
            o_wake_reg   <= (sync_reg == SYNC_BOOT) ? 32'd0 : acc_reg;
            o_decode_reg <= (sync_reg == SYNC_QUASI) || (sync_reg == SYNC_SYNCED);
            o_run_reg    <= (sync_reg == SYNC_SYNCED) || (sync_reg == SYNC_UNS1);
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.sync_state_out  = o_state_reg;
    assign result.guard_out       = o_guard_reg;
    assign result.ref_tick_out    = o_ref_reg;
    assign result.skew_out        = o_skew_reg;
    assign result.wake_tick       = o_wake_reg;
    assign result.decode_schedule = o_decode_reg;
    assign result.run_data_round  = o_run_reg;

endmodule

// ===== hdl/rsync_checker.sv =====
`include "assert_macros.svh"

module rsync_checker
    import rsync_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  sync_state_out,
    input logic [31:0] skew_out,
    input logic [31:0] wake_tick,
    input logic        decode_schedule,
    input logic        run_data_round
);

    // stalled result holds
    `RSYNC_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(wake_tick) && $stable(skew_out))

    // bootstrap carries no skew and no wake time
    `RSYNC_ASSERT_IMP(a_boot_zero, out_valid && (sync_state_out == SYNC_BOOT),
        (wake_tick == 32'd0) && (skew_out == 32'd0))

    `RSYNC_ASSERT_IMP(a_flags, out_valid,
        (decode_schedule == ((sync_state_out == SYNC_QUASI) ||
                             (sync_state_out == SYNC_SYNCED))) &&
        (run_data_round == ((sync_state_out == SYNC_SYNCED) ||
                            (sync_state_out == SYNC_UNS1))))

    // busy after a transfer in, and no result the cycle after
    `RSYNC_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready && !$rose(out_valid))

endmodule

bind round_sync_tracker rsync_checker u_rsync_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (sched_rx.valid),
    .in_ready        (sched_rx.ready),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .sync_state_out  (result.sync_state_out),
    .skew_out        (result.skew_out),
    .wake_tick       (result.wake_tick),
    .decode_schedule (result.decode_schedule),
    .run_data_round  (result.run_data_round)
);

// ===== bench/round_sync_checker.sv =====
`timescale 1ns / 100ps

module round_sync_checker
    import rsync_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    rsync_in_if                   sched_mon,
    rsync_out_if                  result_mon,
    output int unsigned           mismatches,
    output int unsigned           pending
);

    typedef struct packed
    {
        logic [2:0]  state;
        logic [15:0] guard;
        logic [31:0] ref_tick;
        logic [31:0] skew;
        logic [31:0] wake;
        logic        decode;
        logic        run;
    } round_result_t;

    logic [15:0] tps;
    logic [15:0] g_sync;
    logic [15:0] g_miss1;
    logic [15:0] g_miss2;
    logic [15:0] g_wide;
    logic [7:0]  min_len;
    logic [7:0]  sched_code;

    sync_state_t st;
    logic [15:0] guard;
    logic [31:0] ref_now;
    logic [31:0] ref_prev;
    logic [31:0] skew;
    logic [31:0] time_prev;
    logic [15:0] period_prev;

    round_result_t expected_rounds [$];
    round_result_t want;
    int unsigned   mismatch_count = 0;

    assign mismatches = mismatch_count;

    function automatic logic [31:0] project_tick(input logic [31:0] base,
                                                 input logic [15:0] period);
        logic [31:0] p;
        p = {16'd0, period};
        return base + p * {16'd0, tps} + p * skew;
    endfunction

    function automatic void update_skew(input logic [31:0] new_time);
        logic [31:0] dt;
        logic [31:0] diff;
        longint      q;
        dt   = new_time - time_prev;
        diff = (ref_now - ref_prev) - {16'd0, tps} * dt;
        if (dt != 32'd0)
        begin
            q    = longint'($signed(diff)) / longint'($signed(dt));
            skew = q[31:0];
        end
    endfunction

    function automatic round_result_t predict_round(input logic flood,
                                                    input logic [7:0] plen,
                                                    input logic [7:0] code,
                                                    input logic [31:0] rx_ref,
                                                    input logic [31:0] rx_time,
                                                    input logic [15:0] rx_period);
        round_result_t r;
        logic          good;
        good   = flood && (plen >= min_len) && (code == sched_code);
        r.wake = '0;
        if (good)
        begin
            ref_now = rx_ref;
            if (st == SYNC_BOOT)
            begin
                st    = SYNC_QUASI;
                guard = g_wide;
            end
            else
            begin
                st    = SYNC_SYNCED;
                guard = g_sync;
                update_skew(rx_time);
            end
        end
        else
        begin
            case (st)
                SYNC_SYNCED:
                begin
                    st    = SYNC_UNS1;
                    guard = g_miss1;
                end
                SYNC_UNS1:
                begin
                    st    = SYNC_UNS2;
                    guard = g_miss2;
                end
                SYNC_UNS2:
                begin
                    st    = SYNC_UNS3;
                    guard = g_wide;
                end
                SYNC_UNS3, SYNC_QUASI:
                begin
                    st    = SYNC_BOOT;
                    guard = g_wide;
                    skew  = '0;
                end
                default: ;
            endcase
            if (st != SYNC_BOOT)
                ref_now = project_tick(ref_prev, period_prev);
        end
        if (st != SYNC_BOOT)
        begin
            if (st == SYNC_QUASI || st == SYNC_SYNCED)
            begin
                time_prev   = rx_time;
                period_prev = rx_period;
            end
            else
                time_prev = time_prev + {16'd0, period_prev};
            ref_prev = ref_now;
            r.wake   = project_tick(ref_now, period_prev) - {16'd0, guard};
        end
        r.state    = st;
        r.guard    = guard;
        r.ref_tick = ref_now;
        r.skew     = skew;
        r.decode   = (st == SYNC_QUASI || st == SYNC_SYNCED);
        r.run      = (st == SYNC_SYNCED || st == SYNC_UNS1);
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            if (mismatch_count < 10)
                $display("%0t %s: expected %h, got %h", $realtime, field, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps         = RST_TPS;
            g_sync      = RST_GUARD_SYNCED;
            g_miss1     = RST_GUARD_MISS1;
            g_miss2     = RST_GUARD_MISS2;
            g_wide      = RST_GUARD_WIDE;
            min_len     = RST_MIN_LEN;
            sched_code  = RST_PKT_CODE;
            st          = SYNC_BOOT;
            guard       = '0;
            ref_now     = '0;
            ref_prev    = '0;
            skew        = '0;
            time_prev   = '0;
            period_prev = '0;
            expected_rounds.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TPS:          tps        = cfg_data;
                    CFG_GUARD_SYNCED: g_sync     = cfg_data;
                    CFG_GUARD_MISS1:  g_miss1    = cfg_data;
                    CFG_GUARD_MISS2:  g_miss2    = cfg_data;
                    CFG_GUARD_WIDE:   g_wide     = cfg_data;
                    CFG_MIN_LEN:      min_len    = cfg_data[7:0];
                    CFG_PKT_CODE:     sched_code = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (result_mon.valid && result_mon.ready)
            begin
                if (expected_rounds.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t result transfer with nothing expected, state %0d",
                                 $realtime, result_mon.sync_state_out);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_rounds.pop_front();
                    check_field("sync_state_out", 32'(want.state),
                                32'(result_mon.sync_state_out));
                    check_field("guard_out", 32'(want.guard), 32'(result_mon.guard_out));
                    check_field("ref_tick_out", want.ref_tick, result_mon.ref_tick_out);
                    check_field("skew_out", want.skew, result_mon.skew_out);
                    check_field("wake_tick", want.wake, result_mon.wake_tick);
                    check_field("decode_schedule", 32'(want.decode),
                                32'(result_mon.decode_schedule));
                    check_field("run_data_round", 32'(want.run),
                                32'(result_mon.run_data_round));
                end
            end
            if (sched_mon.valid && sched_mon.ready)
                expected_rounds.push_back(predict_round(sched_mon.flood_synced,
                                                        sched_mon.payload_len,
                                                        sched_mon.pkt_code,
                                                        sched_mon.rx_ref_tick,
                                                        sched_mon.rx_sched_time,
                                                        sched_mon.rx_round_period));
            pending <= expected_rounds.size();
        end
    end

endmodule

// ===== bench/round_sync_tracker_test.sv =====
`timescale 1ns / 100ps

module round_sync_tracker_test;
    import rsync_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned PHASE_ITEMS  = 165;

    typedef struct
    {
        logic        flood;
        logic [7:0]  plen;
        logic [7:0]  code;
        logic [31:0] ref_tick;
        logic [31:0] sched_time;
        logic [15:0] period;
    } sched_item_t;

    typedef struct
    {
        logic [15:0] tps;
        logic [15:0] g_sync;
        logic [15:0] g_miss1;
        logic [15:0] g_miss2;
        logic [15:0] g_wide;
        logic [7:0]  min_len;
        logic [7:0]  code;
    } reg_set_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int unsigned           mismatches;
    int unsigned           pending;
    int unsigned           cycle_count;
    int unsigned           src_idle;
    int unsigned           dst_idle;

    reg_set_t    regs;
    logic [31:0] net_time;
    logic [31:0] net_ref;
    logic [15:0] net_period;
    int          drift;

    sched_item_t directed [$];
    sched_item_t item;

    rsync_in_if  sched_ch ();
    rsync_out_if result_ch ();

    round_sync_tracker u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sched_rx  (sched_ch),
        .result    (result_ch)
    );

    round_sync_checker u_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sched_mon  (sched_ch),
        .result_mon (result_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("round_sync_tracker: mismatch");
        $finish;
    end

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(99) >= dst_idle);
        end
    end

    function automatic sched_item_t mk(input logic f, input logic [7:0] pl,
                                       input logic [7:0] c, input logic [31:0] rf,
                                       input logic [31:0] tm, input logic [15:0] pd);
        sched_item_t it;
        it.flood      = f;
        it.plen       = pl;
        it.code       = c;
        it.ref_tick   = rf;
        it.sched_time = tm;
        it.period     = pd;
        return it;
    endfunction

    function automatic logic [15:0] new_period();
        if ($urandom_range(19) == 0)
            return 16'($urandom);
        return 16'($urandom_range(60, 1));
    endfunction

    function automatic reg_set_t random_regs();
        reg_set_t s;
        s.tps     = 16'($urandom_range(65535, 1));
        s.g_sync  = 16'($urandom);
        s.g_miss1 = 16'($urandom);
        s.g_miss2 = 16'($urandom);
        s.g_wide  = 16'($urandom);
        s.min_len = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(40));
        s.code    = 8'($urandom);
        return s;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic program_regs(input reg_set_t s);
        write_reg(CFG_TPS, s.tps);
        write_reg(CFG_GUARD_SYNCED, s.g_sync);
        write_reg(CFG_GUARD_MISS1, s.g_miss1);
        write_reg(CFG_GUARD_MISS2, s.g_miss2);
        write_reg(CFG_GUARD_WIDE, s.g_wide);
        write_reg(CFG_MIN_LEN, {8'd0, s.min_len});
        write_reg(CFG_PKT_CODE, {8'd0, s.code});
        cfg_we <= 1'b0;
        regs = s;
    endtask

    task automatic send_item(input sched_item_t it);
        while ($urandom_range(99) < src_idle)
        begin
            sched_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sched_ch.valid           <= 1'b1;
        sched_ch.flood_synced    <= it.flood;
        sched_ch.payload_len     <= it.plen;
        sched_ch.pkt_code        <= it.code;
        sched_ch.rx_ref_tick     <= it.ref_tick;
        sched_ch.rx_sched_time   <= it.sched_time;
        sched_ch.rx_round_period <= it.period;
        @(posedge clk);
        while (!sched_ch.ready)
            @(posedge clk);
    endtask

    // pending is updated by nonblocking assignment, so once drain has waited
    // past the last transfer it already includes that item
    task automatic drain();
        sched_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic next_item(output sched_item_t it);
        int unsigned pick;
        logic [31:0] p32;
        pick = $urandom_range(99);
        if ($urandom_range(9) == 0)
            net_period = new_period();
        if (pick < 4)
        begin
            net_time   = $urandom;
            net_ref    = $urandom;
            net_period = new_period();
        end
        else if (pick >= 7)
        begin
            p32      = {16'd0, net_period};
            net_time = net_time + p32;
            net_ref  = net_ref + p32 * regs.tps + p32 * 32'(drift)
                     + 32'(int'($urandom_range(40)) - 20);
        end
        // picks 4..6 keep the schedule time: zero time change
        it = mk(1'b1, 8'($urandom_range(255, regs.min_len)), regs.code,
                net_ref, net_time, net_period);
        if (pick >= 92)
            it = mk(1'($urandom_range(1)), 8'($urandom), 8'($urandom),
                    $urandom, $urandom, 16'($urandom));
        else if (pick >= 70)
        begin
            case ($urandom_range(2))
                0: it.flood = 1'b0;
                1:
                begin
                    if (regs.min_len > 0)
                        it.plen = 8'($urandom_range(regs.min_len - 1));
                    else
                        it.flood = 1'b0;
                end
                default: it.code = regs.code ^ 8'($urandom_range(255, 1));
            endcase
        end
    endtask

    initial
    begin
        reg_set_t s;
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_index                = '0;
        cfg_data                 = '0;
        sched_ch.valid           = 1'b0;
        sched_ch.flood_synced    = 1'b0;
        sched_ch.payload_len     = '0;
        sched_ch.pkt_code        = '0;
        sched_ch.rx_ref_tick     = '0;
        sched_ch.rx_sched_time   = '0;
        sched_ch.rx_round_period = '0;
        src_idle                 = 26;
        dst_idle                 = 83;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        s = '{16'd32768, 16'd16, 16'd32, 16'd64, 16'd128, 8'd8, 8'd0};
        program_regs(s);

        // misses in bootstrap, one field wrong at a time
        directed.push_back(mk(1'b0, 8'd8, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        directed.push_back(mk(1'b1, 8'd7, 8'd0, 32'd5, 32'd6, 16'd7));
        directed.push_back(mk(1'b1, 8'd255, 8'd1, 32'd5, 32'd6, 16'd7));
        // quasi, then back to bootstrap
        directed.push_back(mk(1'b1, 8'd8, 8'd0, 32'd1000, 32'd100, 16'd10));
        directed.push_back(mk(1'b0, 8'd0, 8'd255, 32'd0, 32'd0, 16'd0));
        // quasi, synced, equal time, walk down the unsynced states
        directed.push_back(mk(1'b1, 8'd255, 8'd0, 32'd5000, 32'd200, 16'hFFFF));
        directed.push_back(mk(1'b1, 8'd8, 8'd0, 32'd5000 + 32'd327730, 32'd210, 16'd10));
        directed.push_back(mk(1'b1, 8'd8, 8'd0, 32'd5000 + 32'd655000, 32'd210, 16'd10));
        directed.push_back(mk(1'b0, 8'd8, 8'd0, 32'd0, 32'd0, 16'd0));
        directed.push_back(mk(1'b1, 8'd3, 8'd0, 32'd0, 32'd0, 16'd0));
        directed.push_back(mk(1'b1, 8'd8, 8'd9, 32'd0, 32'd0, 16'd0));
        directed.push_back(mk(1'b0, 8'd255, 8'd0, 32'd0, 32'd0, 16'd0));
        // zero period, wrapped ticks and a negative time change
        directed.push_back(mk(1'b1, 8'd8, 8'd0, 32'd0, 32'd0, 16'd0));
        directed.push_back(mk(1'b1, 8'd200, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1));
        directed.push_back(mk(1'b1, 8'd8, 8'd128, 32'd0, 32'd0, 16'd0));
        directed.push_back(mk(1'b1, 8'd8, 8'd0, 32'h1000_0000, 32'd500, 16'd3));
        // most negative difference over a time change of minus one
        directed.push_back(mk(1'b1, 8'd8, 8'd0, 32'h1000_0000 + 32'h8000_0000 - 32'(regs.tps),
                              32'd499, 16'd3));
        directed.push_back(mk(1'b0, 8'd8, 8'd0, 32'd0, 32'd0, 16'd0));
        directed.push_back(mk(1'b1, 8'd0, 8'd0, 32'd0, 32'd0, 16'd0));
        directed.push_back(mk(1'b1, 8'd8, 8'd0, 32'h7FFF_0000, 32'h4000_0000, 16'hFFFF));
        foreach (directed[i])
            send_item(directed[i]);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph / 2)
                0:
                begin
                    src_idle = 26;
                    dst_idle = 83;
                end
                1:
                begin
                    src_idle = 83;
                    dst_idle = 26;
                end
                default:
                begin
                    src_idle = 0;
                    dst_idle = 0;
                end
            endcase
            if (ph == 1 || ph == 5)
                s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF};
            else if (ph == 2)
                s = '{16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0};
            else
                s = random_regs();
            program_regs(s);
            net_time   = $urandom;
            net_ref    = $urandom;
            net_period = new_period();
            drift      = int'($urandom_range(400)) - 200;
            repeat (PHASE_ITEMS)
            begin
                next_item(item);
                send_item(item);
                if ($urandom_range(59) == 0)
                    drain();
            end
            drain();
        end

        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("round_sync_tracker: match");
        else
            $display("round_sync_tracker: mismatch");
        $finish;
    end

endmodule
